FILE: rtl/assert_macros.svh
// Assertion macros used by the port-level checker of this block.
// No dependencies; include with the bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NXT(name, clk, rst_n, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

FILE: rtl/rmts_pkg.sv
// Types and codes of the rate-monotonic tick scheduler.
// No dependencies; used by the top level and its checker.
package rmts_pkg;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef struct packed {
		logic        command;
		logic [2:0]  task_slot;
		logic [15:0] exec_time;
		logic [15:0] period_length;
	} req_t;

	typedef struct packed {
		logic       busy_res;
		logic [2:0] running_task;
		logic [7:0] released_mask;
	} rsp_t;

endpackage

FILE: rtl/rate_monotonic_tick_scheduler.sv
// A load gives no result and leaves the block idle. A tick with n = min(active_tasks, MAX_TASKS)
// entries scans one table entry per cycle through the state memory port, then passes the
// drain and fix states and shows its result (with n of 0 it goes straight to the fix state),
// and the next request can be accepted in the cycle that shows the result.
// Reset (arst_n low) clears active_tasks and the per-entry valid flags, so every counter
// and used time reads as zero; the period and execution tables stay undefined until loaded.
// Depends on rmts_pkg.
module rate_monotonic_tick_scheduler #(
	parameter int MAX_TASKS = 8,
	parameter int TIME_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  rmts_pkg::req_t req,
	output logic          done,
	output rmts_pkg::rsp_t result,
	input  logic          cfg_we,
	input  logic [3:0]    cfg_data
);

	localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CNT_W = $clog2(MAX_TASKS + 1);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_FIX} state_t;

	state_t               state_q;
	logic [3:0]           active_q;
	logic [CNT_W-1:0]     n_q;
	logic [IDX_W-1:0]     rd_idx_q;
	logic                 found_q;
	logic [IDX_W-1:0]     best_idx_q;
	logic [TIME_BITS-1:0] best_per_q;
	logic [TIME_BITS-1:0] best_used_q;
	logic [TIME_BITS-1:0] best_cnt_q;
	logic                 best_rel_q;
	logic [7:0]           mask_q;
	logic [MAX_TASKS-1:0] vld_q;

	// Entry layouts: table memory {period, exec}, counter memory {counter, used}.
	logic [2*TIME_BITS-1:0] mem_a [MAX_TASKS];
	logic [2*TIME_BITS-1:0] mem_b [MAX_TASKS];

	logic                   s1_valid;
	logic [IDX_W-1:0]       idx_s1;
	logic [2*TIME_BITS-1:0] a_rd_s1;
	logic [2*TIME_BITS-1:0] b_rd_s1;
	logic                   vld_s1;

	logic                   accept;
	logic                   load_ok;
	logic [IDX_W-1:0]       slot_idx;
	logic [31:0]            exec_ext;
	logic [31:0]            per_ext;
	logic [CNT_W-1:0]       n_new;

	logic [TIME_BITS-1:0]   per_s1;
	logic [TIME_BITS-1:0]   exec_s1;
	logic [TIME_BITS-1:0]   cnt_s1;
	logic [TIME_BITS-1:0]   used_s1;
	logic [TIME_BITS-1:0]   cnt_nx;
	logic                   rel_s1;
	logic                   take_s1;
	logic [7:0]             rel_bit;

	logic                   b_we;
	logic [IDX_W-1:0]       b_waddr;
	logic [2*TIME_BITS-1:0] b_wdata;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign load_ok  = accept && (req.command == rmts_pkg::CMD_LOAD)
		&& (32'(req.task_slot) < MAX_TASKS);
	assign slot_idx = IDX_W'(req.task_slot);
	assign exec_ext = {16'b0, req.exec_time};
	assign per_ext  = {16'b0, req.period_length};

	always_comb begin
		if (32'(active_q) > MAX_TASKS) begin
			n_new = CNT_W'(MAX_TASKS);
		end else begin
			n_new = CNT_W'(active_q);
		end
	end

	// An entry never written since reset reads as counter and used time zero.
	always_comb begin
		per_s1  = a_rd_s1[2*TIME_BITS-1:TIME_BITS];
		exec_s1 = a_rd_s1[TIME_BITS-1:0];
		cnt_s1  = vld_s1 ? b_rd_s1[2*TIME_BITS-1:TIME_BITS] : '0;
		used_s1 = vld_s1 ? b_rd_s1[TIME_BITS-1:0] : '0;
		cnt_nx  = cnt_s1 + 1'b1;
		rel_s1  = (cnt_nx == per_s1);
		take_s1 = (used_s1 < exec_s1) && (!found_q || (per_s1 < best_per_q));
		rel_bit = '0;
		for (int j = 0; j < 8; j++) begin
			if (32'(idx_s1) == j) begin
				rel_bit[j] = rel_s1;
			end
		end
	end

	// Single write port of the counter memory: load, scan write-back, or the
	// deferred used-time increment of the task that ran.
	always_comb begin
		b_we    = 1'b0;
		b_waddr = idx_s1;
		b_wdata = rel_s1 ? '0 : {cnt_nx, used_s1};
		if (load_ok) begin
			b_we    = 1'b1;
			b_waddr = slot_idx;
			b_wdata = '0;
		end else if (s1_valid) begin
			b_we    = 1'b1;
		end else if (state_q == ST_FIX && found_q && !best_rel_q) begin
			b_we    = 1'b1;
			b_waddr = best_idx_q;
			b_wdata = {best_cnt_q, best_used_q + 1'b1};
		end
	end

	always_ff @(posedge clk) begin
		if (load_ok) begin
			mem_a[slot_idx] <= {per_ext[TIME_BITS-1:0], exec_ext[TIME_BITS-1:0]};
		end
		if (b_we) begin
			mem_b[b_waddr] <= b_wdata;
		end
		if (state_q == ST_SCAN) begin
			a_rd_s1 <= mem_a[rd_idx_q];
			b_rd_s1 <= mem_b[rd_idx_q];
			vld_s1  <= vld_q[rd_idx_q];
			idx_s1  <= rd_idx_q;
		end
		if (s1_valid && take_s1) begin
			best_idx_q  <= idx_s1;
			best_per_q  <= per_s1;
			best_used_q <= used_s1;
			best_cnt_q  <= cnt_nx;
			best_rel_q  <= rel_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			active_q <= '0;
			n_q      <= '0;
			rd_idx_q <= '0;
			found_q  <= 1'b0;
			mask_q   <= '0;
			vld_q    <= '0;
			s1_valid <= 1'b0;
			done     <= 1'b0;
			result   <= '0;
		end else begin
			done     <= (state_q == ST_FIX);
			s1_valid <= (state_q == ST_SCAN);
			if (cfg_we) begin
				active_q <= cfg_data;
			end
			if (b_we) begin
				vld_q[b_waddr] <= 1'b1;
			end
			if (s1_valid) begin
				mask_q <= mask_q | rel_bit;
				if (take_s1) begin
					found_q <= 1'b1;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept && req.command == rmts_pkg::CMD_TICK) begin
						n_q      <= n_new;
						rd_idx_q <= '0;
						found_q  <= 1'b0;
						mask_q   <= '0;
						state_q  <= (n_new == '0) ? ST_FIX : ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (CNT_W'(rd_idx_q) + 1'b1 == n_q) begin
						state_q <= ST_DRAIN;
					end else begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_FIX;
				end
				ST_FIX: begin
					result.busy_res      <= found_q;
					result.running_task  <= found_q ? 3'(best_idx_q) : 3'd0;
					result.released_mask <= mask_q;
					state_q              <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: rtl/rmts_checker.sv
// Port-level checks of the rate-monotonic tick scheduler, bound to its top level.
// Depends on rmts_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rmts_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input rmts_pkg::req_t req,
	input logic           done,
	input rmts_pkg::rsp_t result
);

	logic load_acc;
	logic tick_acc;

	assign load_acc = start && !busy && (req.command == rmts_pkg::CMD_LOAD);
	assign tick_acc = start && !busy && (req.command == rmts_pkg::CMD_TICK);

	// A result is shown only once the tick request has finished its scan.
	`ASSERT_IMP(a_done_not_busy, clk, arst_n, done, !busy)
	`ASSERT_IMP(a_idle_task_zero, clk, arst_n, done && !result.busy_res, result.running_task == 3'd0)
	`ASSERT_NXT(a_load_one_cycle, clk, arst_n, load_acc, !busy && !done)
	`ASSERT_NXT(a_tick_goes_busy, clk, arst_n, tick_acc, busy)
	`ASSERT_NXT(a_single_result, clk, arst_n, done, !done)

endmodule

bind rate_monotonic_tick_scheduler rmts_checker u_rmts_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.req    (req),
	.done   (done),
	.result (result)
);

FILE: tb/sv/rmts_checker.sv
// Checker for the rate-monotonic tick scheduler: keeps its own copy of the task table,
// predicts the outcome of every accepted tick request and compares the strobed results.
// Depends on rmts_pkg.
module rmts_tb_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           busy,
	input  rmts_pkg::req_t req,
	input  logic           done,
	input  rmts_pkg::rsp_t result,
	input  logic           cfg_we,
	input  logic [3:0]     cfg_data,
	output int             mismatches,
	output int             outstanding
);

	logic [15:0]    period_of [8];
	logic [15:0]    exec_of [8];
	logic [15:0]    count_of [8];
	logic [15:0]    used_of [8];
	logic [3:0]     active_cnt;
	rmts_pkg::rsp_t tick_outcomes [$];
	rmts_pkg::rsp_t oldest;

	// Picks the entry that runs this tick, charges it one unit and advances every period.
	function automatic rmts_pkg::rsp_t run_tick();
		int             n;
		int             pick;
		bit             found;
		rmts_pkg::rsp_t o;
		n = (active_cnt > 4'd8) ? 8 : int'(active_cnt);
		found = 1'b0;
		pick = 0;
		o = '0;
		for (int k = 0; k < n; k++) begin
			if (used_of[k] < exec_of[k] && (!found || period_of[k] < period_of[pick])) begin
				pick = k;
				found = 1'b1;
			end
		end
		if (found) begin
			used_of[pick] = used_of[pick] + 16'd1;
			o.busy_res = 1'b1;
			o.running_task = pick[2:0];
		end
		for (int k = 0; k < n; k++) begin
			count_of[k] = count_of[k] + 16'd1;
			if (count_of[k] == period_of[k]) begin
				count_of[k] = '0;
				used_of[k] = '0;
				o.released_mask[k] = 1'b1;
			end
		end
		return o;
	endfunction

	function automatic void check_field(string field, int want, int got);
		if (want != got) begin
			$display("%0t: tick result %s mismatch: expected %0d, actual %0d",
				$time, field, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 8; k++) begin
				count_of[k] = '0;
				used_of[k] = '0;
			end
			active_cnt = '0;
			tick_outcomes.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			// Compare first: a new request may be accepted on the edge that shows a result.
			if (done === 1'b1) begin
				if (tick_outcomes.size() == 0) begin
					$display("%0t: tick result with no tick request outstanding", $time);
					mismatches++;
				end else begin
					oldest = tick_outcomes.pop_front();
					check_field("busy_res", oldest.busy_res, result.busy_res);
					check_field("running_task", oldest.running_task, result.running_task);
					check_field("released_mask", oldest.released_mask, result.released_mask);
				end
			end
			if (cfg_we) begin
				active_cnt = cfg_data;
			end
			if (start && !busy) begin
				if (req.command == rmts_pkg::CMD_LOAD) begin
					exec_of[req.task_slot] = req.exec_time;
					period_of[req.task_slot] = req.period_length;
					count_of[req.task_slot] = '0;
					used_of[req.task_slot] = '0;
				end else begin
					tick_outcomes.push_back(run_tick());
				end
			end
			outstanding = tick_outcomes.size();
		end
	end

endmodule

FILE: tb/sv/rate_monotonic_tick_scheduler_tb.sv
// Testbench top for the rate-monotonic tick scheduler: drives load and tick requests and
// the active_tasks register, and reports the verdict of the checker beside the block.
// Depends on rmts_pkg, rate_monotonic_tick_scheduler and rmts_tb_checker.
module rate_monotonic_tick_scheduler_tb;

	logic           clk = 1'b0;
	logic           arst_n;
	logic           start;
	logic           busy;
	rmts_pkg::req_t req;
	logic           done;
	rmts_pkg::rsp_t result;
	logic           cfg_we;
	logic [3:0]     cfg_data;
	int             mismatches;
	int             outstanding;
	logic [3:0]     phase_active [4] = '{4'd8, 4'd1, 4'd15, 4'd0};

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	rate_monotonic_tick_scheduler #(
		.MAX_TASKS(8),
		.TIME_BITS(16)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data)
	);

	rmts_tb_checker tick_check (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	// Holds the request on the inputs until the block takes it.
	task automatic send(rmts_pkg::req_t r);
		@(negedge clk);
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	task automatic hold_off(int cycles);
		repeat (cycles) begin
			@(negedge clk);
			start <= 1'b0;
		end
	endtask

	task automatic wait_results();
		@(negedge clk);
		start <= 1'b0;
		while (outstanding != 0) @(negedge clk);
	endtask

	// The register is written only while no request is in flight.
	task automatic write_active(logic [3:0] value);
		wait_results();
		cfg_we <= 1'b1;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic rmts_pkg::req_t load_req(int slot, int exec_units, int period);
		rmts_pkg::req_t r;
		r.command = rmts_pkg::CMD_LOAD;
		r.task_slot = slot[2:0];
		r.exec_time = exec_units[15:0];
		r.period_length = period[15:0];
		return r;
	endfunction

	function automatic rmts_pkg::req_t tick_req();
		rmts_pkg::req_t r;
		r = load_req($urandom_range(0, 7), $urandom_range(0, 65535), $urandom_range(0, 65535));
		r.command = rmts_pkg::CMD_TICK;
		return r;
	endfunction

	// Mostly short periods and small budgets so that releases and preemption happen often.
	function automatic rmts_pkg::req_t random_req();
		if ($urandom_range(0, 3) != 0) begin
			return tick_req();
		end
		if ($urandom_range(0, 5) == 0) begin
			return load_req($urandom_range(0, 7), $urandom_range(0, 65535),
				$urandom_range(1, 65535));
		end
		return load_req($urandom_range(0, 7), $urandom_range(0, 5), $urandom_range(1, 12));
	endfunction

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_data = '0;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		// With no active entries a tick is idle and releases nothing.
		send(tick_req());
		send(load_req(0, 2, 5));
		send(load_req(1, 1, 3));
		send(load_req(2, 65535, 65535));
		send(load_req(3, 0, 1));
		send(load_req(4, 1, 3));
		send(load_req(5, 3, 0));
		send(load_req(6, 1, 2));
		send(load_req(7, 2, 4));
		// Fifteen active entries count as the whole table.
		write_active(4'd15);
		repeat (5) send(tick_req());
		send(load_req(5, 1, 2));
		repeat (6) send(tick_req());

		for (int phase = 0; phase < 9; phase++) begin
			write_active((phase < 4) ? phase_active[phase] : 4'($urandom_range(0, 15)));
			for (int i = 0; i < 50; i++) begin
				if (phase < 7) begin
					if ($urandom_range(0, 4) == 0) begin
						hold_off($urandom_range(1, 11));
					end
					if ($urandom_range(0, 39) == 0) begin
						wait_results();
					end
				end
				send(random_req());
			end
		end

		wait_results();
		repeat (20) @(negedge clk);
		if (mismatches == 0 && outstanding == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
